// ===== rtl/pna_pkg.sv =====
// Package for the port number allocator: defaults, command, status and sequencer types.
`timescale 1ns / 1ps

package pna_pkg;

	// Default sizes of the port space and of one usage map word
	localparam int unsigned NUM_PORTS_DEF     = 65536;
	localparam int unsigned MAP_WORD_BITS_DEF = 64;

	// Field widths of the stream items
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned PORT_W   = 16;
	localparam int unsigned STATUS_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_BIND_NAMED = 2'd0,
		CMD_BIND_ANY   = 2'd1,
		CMD_FREE       = 2'd2,
		CMD_NOP        = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_PORT_ZERO = 3'd1,
		ST_IN_USE    = 3'd2,
		ST_NONE_FREE = 3'd3,
		ST_NOT_BOUND = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,  // sweep zeros through the usage map after reset
		S_IDLE,   // wait for an item
		S_DIV,    // reciprocal multiply: estimate of the map word
		S_FIX,    // correct word and bit, screen port zero and range
		S_RD,     // read the map word of a named port
		S_CHK,    // test the bit, update the map, set the result
		S_SRD,    // read the next map word of a free-port search
		S_SCHK,   // isolate the lowest free bit of that word
		S_SENC,   // encode the isolated bit to a bit index
		S_SFIN,   // form the candidate port number
		S_SWR,    // range check, mark the port used, set the result
		S_DONE    // hand the result to the output register
	} state_t;

endpackage

// ===== rtl/port_number_allocator_unit.sv =====
// Port number allocator: usage bitmap in a memory, walked by a small sequencer.
`timescale 1ns / 1ps

// Usage
//   Input channel s_axis_*: one item per request. tuser carries the command
//   (bind named port, bind any free port, free port, no operation), tdata the
//   port number. Output channel m_axis_*: exactly one result per request, the
//   granted port (0 when none) and a status code.
//   The block handles one request at a time and drops s_axis_tready while busy.
//   Steps: bind named and free run S_DIV, S_FIX, S_RD, S_CHK and S_DONE; a bind that
//   names port zero, or a request whose port lies outside the map, goes from S_FIX
//   straight to S_DONE, and no operation goes from idle straight to S_DONE. Bind any
//   reads and tests one map word per S_SRD, S_SCHK pair until a word has a free bit,
//   then runs S_SENC, S_SFIN, S_SWR and S_DONE; a full map goes to S_DONE after its
//   last word is tested. The registered map read splits each word into read and test.
//   Reset: after arst_n rises the block runs a clearing pass over the MAP_WORDS map words
//   (1024 with default sizes), writing one zero word per cycle, with s_axis_tready
//   low; afterwards every port is free.
//   Output stall: the result sits in an output register; the next request is
//   accepted meanwhile and waits in its last step until the register is free.
module port_number_allocator_unit #(
	parameter int unsigned NUM_PORTS     = pna_pkg::NUM_PORTS_DEF,
	parameter int unsigned MAP_WORD_BITS = pna_pkg::MAP_WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] port_number
	input  logic [1:0]  s_axis_tuser,   // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [15:0] granted_port, [18:16] status, [23:19] zero
);

	import pna_pkg::*;

	localparam int unsigned MAP_WORDS = (NUM_PORTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BIT_W     = $clog2(MAP_WORD_BITS);
	localparam int unsigned DIV_SHIFT = 24;
	localparam int unsigned RECIP     = (1 << DIV_SHIFT) / MAP_WORD_BITS;
	localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
	localparam int unsigned PROD_W    = PORT_W + RECIP_W;
	localparam int unsigned Q_W       = PROD_W - DIV_SHIFT;
	localparam int unsigned EXT_W     = PORT_W + 1;
	localparam int unsigned OUT_W     = 24;

	state_t state_q, state_d;

	// Usage map memory and its access signals
	logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
	logic                     mem_we;
	logic [WORD_AW-1:0]       mem_waddr;
	logic [MAP_WORD_BITS-1:0] mem_wdata;
	logic                     mem_re;
	logic [MAP_WORD_BITS-1:0] rdata_q;

	// Request and work registers
	logic [WORD_AW-1:0]       clr_q;
	cmd_t                     cmd_q;
	logic [PORT_W-1:0]        port_q;
	logic [Q_W-1:0]           q0_q;
	logic [WORD_AW-1:0]       word_q;
	logic [BIT_W-1:0]         bit_q;
	logic [MAP_WORD_BITS-1:0] low_q;
	logic [EXT_W-1:0]         cand_q;
	logic [PORT_W-1:0]        res_port_q;
	status_t                  res_stat_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	// Shared arithmetic
	logic                     s_fire;
	logic                     out_free;
	logic [PROD_W-1:0]        prod;
	logic [EXT_W-1:0]         qw;
	logic [EXT_W-1:0]         rem;
	logic                     corr;
	logic [Q_W-1:0]           fix_word;
	logic [EXT_W-1:0]         fix_bit;
	logic                     in_range;
	logic                     bit_used;
	logic [MAP_WORD_BITS-1:0] free_bits;
	logic [MAP_WORD_BITS-1:0] low_bits;
	logic [BIT_W-1:0]         enc_bit;
	logic                     last_word;
	logic                     cand_ok;

	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// Split the port into map word and bit: reciprocal estimate, then one correction
	always_comb begin
		prod     = PROD_W'(port_q) * PROD_W'(RECIP);
		qw       = EXT_W'(q0_q) * EXT_W'(MAP_WORD_BITS);
		rem      = {1'b0, port_q} - qw;
		corr     = rem >= EXT_W'(MAP_WORD_BITS);
		fix_word = corr ? q0_q + Q_W'(1) : q0_q;
		fix_bit  = corr ? rem - EXT_W'(MAP_WORD_BITS) : rem;
		in_range = {1'b0, port_q} < EXT_W'(NUM_PORTS);
	end

	// Test a named bit and find the lowest free bit of the word just read
	always_comb begin
		bit_used  = rdata_q[bit_q];
		free_bits = ~rdata_q;
		if (word_q == '0) begin
			free_bits[0] = 1'b0;
		end
		low_bits  = free_bits & (~free_bits + MAP_WORD_BITS'(1));
		last_word = word_q == WORD_AW'(MAP_WORDS - 1);
		cand_ok   = cand_q < EXT_W'(NUM_PORTS);
	end

	// Encode the one-hot lowest free bit to its index
	always_comb begin
		enc_bit = '0;
		for (int j = 0; j < BIT_W; j++) begin
			for (int i = 0; i < MAP_WORD_BITS; i++) begin
				if (((i >> j) & 1) == 1) begin
					enc_bit[j] = enc_bit[j] | low_q[i];
				end
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == WORD_AW'(MAP_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_fire) begin
					unique case (cmd_t'(s_axis_tuser))
						CMD_BIND_ANY:               state_d = S_SRD;
						CMD_NOP:                    state_d = S_DONE;
						CMD_BIND_NAMED, CMD_FREE:   state_d = S_DIV;
						default:                    state_d = S_DONE;
					endcase
				end
			end
			S_DIV: state_d = S_FIX;
			S_FIX: begin
				if ((cmd_q == CMD_BIND_NAMED && port_q == '0) || !in_range) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD:   state_d = S_CHK;
			S_CHK:  state_d = S_DONE;
			S_SRD:  state_d = S_SCHK;
			S_SCHK: begin
				if (free_bits != '0) begin
					state_d = S_SENC;
				end else if (last_word) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SENC: state_d = S_SFIN;
			S_SFIN: state_d = S_SWR;
			S_SWR:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: input ready and memory port controls
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = word_q;
		mem_wdata     = rdata_q;
		mem_re        = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: s_axis_tready = 1'b1;
			S_RD, S_SRD: mem_re = 1'b1;
			S_CHK: begin
				if (cmd_q == CMD_BIND_NAMED && !bit_used) begin
					mem_we           = 1'b1;
					mem_wdata[bit_q] = 1'b1;
				end else if (cmd_q == CMD_FREE && bit_used) begin
					mem_we           = 1'b1;
					mem_wdata[bit_q] = 1'b0;
				end
			end
			S_SWR: begin
				mem_we    = cand_ok;
				mem_wdata = rdata_q | low_q;
			end
			default: begin
			end
		endcase
	end

	// Usage map memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[word_q];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + WORD_AW'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q      <= cmd_t'(s_axis_tuser);
				port_q     <= s_axis_tdata;
				word_q     <= '0;
				res_port_q <= '0;
				res_stat_q <= ST_OK;
			end
			S_DIV: q0_q <= prod[PROD_W-1 -: Q_W];
			S_FIX: begin
				word_q <= WORD_AW'(fix_word);
				bit_q  <= fix_bit[BIT_W-1:0];
				if (cmd_q == CMD_BIND_NAMED && port_q == '0) begin
					res_stat_q <= ST_PORT_ZERO;
				end else if (!in_range) begin
					res_stat_q <= (cmd_q == CMD_FREE) ? ST_NOT_BOUND : ST_IN_USE;
				end
			end
			S_CHK: begin
				if (cmd_q == CMD_BIND_NAMED) begin
					if (bit_used) begin
						res_stat_q <= ST_IN_USE;
					end else begin
						res_port_q <= port_q;
					end
				end else if (!bit_used) begin
					res_stat_q <= ST_NOT_BOUND;
				end
			end
			S_SCHK: begin
				low_q <= low_bits;
				if (free_bits == '0) begin
					if (last_word) begin
						res_stat_q <= ST_NONE_FREE;
					end else begin
						word_q <= word_q + WORD_AW'(1);
					end
				end
			end
			S_SENC: bit_q <= enc_bit;
			S_SFIN: cand_q <= EXT_W'(word_q) * EXT_W'(MAP_WORD_BITS) + EXT_W'(bit_q);
			S_SWR: begin
				if (cand_ok) begin
					res_port_q <= cand_q[PORT_W-1:0];
				end else begin
					res_stat_q <= ST_NONE_FREE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q <= {(OUT_W - STATUS_W - PORT_W)'(0), res_stat_q, res_port_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// An accepted item keeps the input closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_axis_tready)
		else $error("input ready while a request is in work");

	// Every error result carries no granted port
	a_error_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[18:16] != ST_OK) |-> m_axis_tdata[15:0] == '0)
		else $error("error result with nonzero granted port");

	// A finished request waits while the output register is stalled
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !m_axis_tready) |=> state_q == S_DONE)
		else $error("result left the sequencer while the output was stalled");

	// No map write outside the clearing pass and the update steps
	a_write_steps: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_CHK || state_q == S_SWR))
		else $error("usage map written outside an update step");

endmodule

// ===== dv/tb_port_number_allocator_unit.sv =====
// Testbench for the port number allocator: usage map tracker, stream drivers and result checks.
`timescale 1ns / 1ps

module tb_port_number_allocator_unit;

	import pna_pkg::*;

	localparam int unsigned PORT_COUNT = NUM_PORTS_DEF;
	localparam int unsigned MAP_WORDS  = (NUM_PORTS_DEF + MAP_WORD_BITS_DEF - 1) / MAP_WORD_BITS_DEF;
	// Slowest search walks the whole map; leave room for it after the last result
	localparam int unsigned TAIL_CYCLES = 2 * MAP_WORDS + 64;
	localparam int unsigned CYCLE_LIMIT = 12_000_000;
	localparam int unsigned RANDOM_ITEMS = 1000;

	// Expected result of one request
	typedef struct {
		logic [PORT_W-1:0] granted;
		status_t           status;
	} grant_t;

	// Tracks which ports are bound and holds the results still to come
	class port_map_tracker;
		bit     port_used [PORT_COUNT];
		grant_t expected_grants [$];
		int     errors;

		// First free port from 1 upward, 0 when the map is full
		function int first_free();
			for (int p = 1; p < PORT_COUNT; p++)
				if (!port_used[p])
					return p;
			return 0;
		endfunction

		function void note_request(cmd_t cmd, logic [PORT_W-1:0] port);
			grant_t g;
			int     p;
			g.granted = '0;
			g.status  = ST_OK;
			case (cmd)
				CMD_BIND_NAMED: begin
					if (port == 0)
						g.status = ST_PORT_ZERO;
					else if (int'(port) >= PORT_COUNT || port_used[port])
						g.status = ST_IN_USE;
					else begin
						port_used[port] = 1'b1;
						g.granted = port;
					end
				end
				CMD_BIND_ANY: begin
					p = first_free();
					if (p == 0)
						g.status = ST_NONE_FREE;
					else begin
						port_used[p] = 1'b1;
						g.granted = PORT_W'(p);
					end
				end
				CMD_FREE: begin
					if (int'(port) >= PORT_COUNT || !port_used[port])
						g.status = ST_NOT_BOUND;
					else
						port_used[port] = 1'b0;
				end
				default: ;
			endcase
			expected_grants.push_back(g);
		endfunction

		function void check_grant(logic [23:0] data);
			grant_t g;
			if (expected_grants.size() == 0) begin
				$display("%0t: unexpected result, actual granted %0d status %0d", $time,
					data[15:0], data[18:16]);
				errors++;
				return;
			end
			g = expected_grants.pop_front();
			if (data[15:0] !== g.granted) begin
				$display("%0t: granted_port mismatch, expected %0d actual %0d", $time,
					g.granted, data[15:0]);
				errors++;
			end
			if (data[18:16] !== g.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d", $time,
					g.status, data[18:16]);
				errors++;
			end
			if (data[23:19] !== 5'd0) begin
				$display("%0t: pad bits mismatch, expected 0 actual %0h", $time, data[23:19]);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_grants.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [15:0] port_number
	logic [1:0]  s_axis_tuser = '0;   // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [15:0] granted_port, [18:16] status, [23:19] zero

	port_map_tracker tracker;
	bit              quiet = 1'b0;
	int              rx_stall = 0;
	int unsigned     cycle_count = 0;

	port_number_allocator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none during quiet stretches
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Favor a small port range so binds and frees collide often
	function automatic logic [15:0] pick_port();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 16'($urandom_range(0, 200));
		if (r < 65)
			return 16'($urandom_range(0, 1023));
		if (r < 94)
			return 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 2))
			0: return 16'd0;
			1: return 16'd1;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return CMD_BIND_NAMED;
		if (r < 60)
			return CMD_BIND_ANY;
		if (r < 95)
			return CMD_FREE;
		return CMD_NOP;
	endfunction

	// Present one item and hold it until accepted; returns on the accepting edge
	task automatic send_item(cmd_t cmd, logic [15:0] port);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= port;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(cmd, port);
	endtask

	// Drop valid and wait for every pending result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	// Result side: take items with random stalls
	always @(posedge clk) begin
		if (m_axis_tvalid === 1'b1 && m_axis_tready)
			tracker.check_grant(m_axis_tdata);
		if (rx_stall > 0) begin
			rx_stall      <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	// Timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [15:0] port;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: port zero, collisions, top port, no-op, search after frees
		send_item(CMD_BIND_NAMED, 16'd0);
		send_item(CMD_FREE, 16'd0);
		send_item(CMD_BIND_ANY, 16'd0);
		send_item(CMD_BIND_NAMED, 16'd1);
		send_item(CMD_BIND_NAMED, 16'hFFFF);
		send_item(CMD_BIND_NAMED, 16'hFFFF);
		send_item(CMD_FREE, 16'hFFFF);
		send_item(CMD_FREE, 16'hFFFF);
		send_item(CMD_NOP, 16'hFFFF);
		send_item(CMD_NOP, 16'd0);
		send_item(CMD_BIND_NAMED, 16'd2);
		send_item(CMD_BIND_ANY, 16'hFFFF);
		send_item(CMD_FREE, 16'd1);
		send_item(CMD_BIND_ANY, 16'h5555);
		send_item(CMD_BIND_NAMED, 16'hAAAA);
		send_item(CMD_BIND_NAMED, 16'h5555);
		send_item(CMD_FREE, 16'd2);
		send_item(CMD_FREE, 16'd3);
		send_item(CMD_BIND_ANY, 16'hAAAA);
		send_item(CMD_BIND_NAMED, 16'd64);
		send_item(CMD_FREE, 16'hAAAA);
		send_item(CMD_FREE, 16'h5555);

		// Hold off until the block has emptied
		drain_results();

		// Random mix with quiet stretches
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i % 300) >= 250;
			send_item(pick_cmd(), pick_port());
		end

		// Searches around frees of a random port and of both ends of the range
		quiet = 1'b0;
		port = 16'($urandom_range(1, 65535));
		send_item(CMD_BIND_ANY, 16'd0);
		send_item(CMD_FREE, port);
		send_item(CMD_BIND_ANY, 16'hFFFF);
		send_item(CMD_BIND_ANY, 16'd0);
		send_item(CMD_FREE, 16'hFFFF);
		send_item(CMD_FREE, 16'd1);
		send_item(CMD_BIND_ANY, 16'd0);
		send_item(CMD_BIND_ANY, 16'd0);
		for (int i = 0; i < 20; i++)
			send_item(pick_cmd(), pick_port());

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pna_pkg.sv
rtl/port_number_allocator_unit.sv
dv/tb_port_number_allocator_unit.sv
